>>> rtl/core/tcbm_pkg.sv
// ----------------------------------------------------------------------------
// tcbm_pkg
// shared widths, defaults and register indexes of the transitive closure unit
// ----------------------------------------------------------------------------
`default_nettype none

package tcbm_pkg;

  // row payload and row index field widths
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned ROW_IDX_W = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned NC_W       = 7;

  // default node capacity
  localparam int unsigned MAX_NODES_DEF = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_LOOPS = 4'd1;

  // register reset values
  localparam logic [NC_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic            SELF_LOOPS_RST = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/tcbm_if.sv
// ----------------------------------------------------------------------------
// tcbm_if
// valid/ready channels of the transitive closure unit
// ----------------------------------------------------------------------------
`default_nettype none

// adjacency row input channel
interface tcbm_row_in_if;
  logic                       valid;
  logic                       ready;
  logic [tcbm_pkg::ROW_W-1:0] row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

// closure row output channel
interface tcbm_row_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcbm_pkg::ROW_W-1:0]     closure_row;
  logic [tcbm_pkg::ROW_IDX_W-1:0] row_index;
  logic                           last_row;

  modport source (output valid, output closure_row, output row_index, output last_row,
                  input ready);
  modport sink   (input valid, input closure_row, input row_index, input last_row,
                  output ready);
endinterface

// configuration write channel
interface tcbm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcbm_pkg::CFG_IDX_W-1:0]  index;
  logic [tcbm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcbm_row_mem.sv
// ----------------------------------------------------------------------------
// tcbm_row_mem
// row store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tcbm_row_mem #(
  parameter int unsigned DEPTH = tcbm_pkg::MAX_NODES_DEF,
  parameter int unsigned WIDTH = tcbm_pkg::ROW_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/transitive_closure_bit_matrix_unit.sv
// ----------------------------------------------------------------------------
// transitive_closure_bit_matrix_unit
// reflexive/transitive closure of a boolean adjacency matrix by Warshall passes
// ----------------------------------------------------------------------------
// load: one row per cycle, the input is ready only while loading
// closure: one pivot pass per node, one row read/or/write per cycle in the sweep, on the
//   single read and single write port of the row store
// emit: per closure row a store read, then an output register load held while the output stalls
// reset: node_count 64, add_self_loops 1, load count 0; row store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module transitive_closure_bit_matrix_unit #(
  parameter int unsigned MAX_NODES = tcbm_pkg::MAX_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcbm_row_in_if.sink           row_in_i,
  tcbm_row_out_if.source        row_out_o,
  tcbm_cfg_if.sink              cfg_i
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned ROW_W = tcbm_pkg::ROW_W;
  localparam int unsigned NC_W  = tcbm_pkg::NC_W;

  // sequencer states
  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,  // taking rows
    S_PIV   = 6'b000010,  // read pivot row k
    S_PCAP  = 6'b000100,  // capture pivot, read row 0
    S_SWEEP = 6'b001000,  // or pivot into rows holding bit k
    S_ERD   = 6'b010000,  // read closure row for output
    S_EOUT  = 6'b100000   // hand closure row to output register
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [NC_W-1:0] node_count_q;
  logic            self_loops_q;

  // sequencer registers
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0] last_idx_q, last_idx_d;  // effective node count minus one
  logic [IDX_W-1:0] k_q, k_d;                // pivot
  logic [IDX_W-1:0] wa_q, wa_d;              // row under work
  logic [ROW_W-1:0] pivot_q, pivot_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [ROW_W-1:0]               out_row_q, out_row_d;
  logic [tcbm_pkg::ROW_IDX_W-1:0] out_idx_q, out_idx_d;
  logic                           out_last_q, out_last_d;

  // row store ports
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ROW_W-1:0] mem_wdata, rd_data;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] cnt_next;
  logic [ROW_W-1:0] load_row;
  logic             in_acc;
  logic             out_free;

  tcbm_row_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (ROW_W)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= tcbm_pkg::NODE_COUNT_RST;
      self_loops_q <= tcbm_pkg::SELF_LOOPS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tcbm_pkg::CFG_NODE_COUNT: node_count_q <= cfg_i.data[NC_W-1:0];
        tcbm_pkg::CFG_SELF_LOOPS: self_loops_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // effective node count, clamped to 1..MAX_NODES
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_q > NC_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(node_count_q);
    end
  end

  // incoming row: drop edges to missing nodes, force own bit if asked
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      load_row[j] = (row_in_i.row_bits[j] && (j < int'(n_eff)))
                 || (self_loops_q && (j == int'(load_cnt_q)) && (load_cnt_q < n_eff));
    end
  end

  assign in_acc   = row_in_i.valid && row_in_i.ready;
  assign out_free = !out_valid_q || row_out_o.ready;

  // slot is only consumed when one is left
  assign cnt_next = (load_cnt_q < CNT_W'(MAX_NODES)) ? CNT_W'(load_cnt_q + 1'b1)
                                                      : load_cnt_q;

  assign row_in_i.ready = (state_q == S_LOAD);

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    last_idx_d  = last_idx_q;
    k_d         = k_q;
    wa_d        = wa_q;
    pivot_d     = pivot_q;
    out_valid_d = out_valid_q && !row_out_o.ready;
    out_row_d   = out_row_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = wa_q;
    mem_wdata   = rd_data | pivot_q;
    mem_re      = 1'b0;
    mem_raddr   = wa_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (load_cnt_q < CNT_W'(MAX_NODES)) begin
            mem_we    = 1'b1;
            mem_waddr = load_cnt_q[IDX_W-1:0];
            mem_wdata = load_row;
          end
          load_cnt_d = cnt_next;
          // enough rows: start the closure over the first n rows
          if (cnt_next >= n_eff) begin
            load_cnt_d = '0;
            last_idx_d = IDX_W'(n_eff - 1'b1);
            k_d        = '0;
            state_d    = S_PIV;
          end
        end
      end
      S_PIV: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
        state_d   = S_PCAP;
      end
      S_PCAP: begin
        pivot_d   = rd_data;
        mem_re    = 1'b1;
        mem_raddr = '0;
        wa_d      = '0;
        state_d   = S_SWEEP;
      end
      S_SWEEP: begin
        // rd_data holds row wa_q, read of the next row goes out in parallel
        if (rd_data[k_q]) begin
          mem_we = 1'b1;
        end
        if (wa_q == last_idx_q) begin
          if (k_q == last_idx_q) begin
            wa_d    = '0;
            state_d = S_ERD;
          end else begin
            k_d     = IDX_W'(k_q + 1'b1);
            state_d = S_PIV;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(wa_q + 1'b1);
          wa_d      = IDX_W'(wa_q + 1'b1);
        end
      end
      S_ERD: begin
        mem_re    = 1'b1;
        mem_raddr = wa_q;
        state_d   = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_row_d   = rd_data;
          out_idx_d   = tcbm_pkg::ROW_IDX_W'(wa_q);
          out_last_d  = (wa_q == last_idx_q);
          if (wa_q == last_idx_q) begin
            state_d = S_LOAD;
          end else begin
            wa_d    = IDX_W'(wa_q + 1'b1);
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and sequencing datapath
  always_ff @(posedge clk_i) begin
    last_idx_q <= last_idx_d;
    k_q        <= k_d;
    wa_q       <= wa_d;
    pivot_q    <= pivot_d;
    out_row_q  <= out_row_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign row_out_o.valid       = out_valid_q;
  assign row_out_o.closure_row = out_row_q;
  assign row_out_o.row_index   = out_idx_q;
  assign row_out_o.last_row    = out_last_q;

endmodule

`default_nettype wire
